FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion violated");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

FILE: rtl/fmvs_pkg.sv
// shared types, constants and helpers of the firmware marker version scanner
package fmvs_pkg;

    localparam int VERSION_MAX_DEF = 32;
    localparam int PREFIX_MAX_DEF  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN  = 2'd2;

    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] version_char;
        logic       version_last;
        logic [5:0] version_length;
    } t_out_req;

    // version character class: alphanumerics and . - _ +
    function automatic logic allowed_char(input logic [7:0] c);
        allowed_char = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
                       ((c >= CH_LA) && (c <= CH_LZ)) || (c == CH_DOT) ||
                       (c == CH_DASH) || (c == CH_UNDER) || (c == CH_PLUS);
    endfunction

endpackage

FILE: rtl/fmvs_ram.sv
// generic single-write single-read ram with registered read data
module fmvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/fmvs_job_q.sv
// two-entry queue of readout jobs between scan front and readout back
module fmvs_job_q #(
    parameter int W = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
endmodule

FILE: rtl/fmvs_front.sv
// scan front: config registers, marker match, version capture, found detection
module fmvs_front #(
    parameter int VERSION_MAX = fmvs_pkg::VERSION_MAX_DEF,
    parameter int PREFIX_MAX  = fmvs_pkg::PREFIX_MAX_DEF,
    localparam int CW = $clog2(VERSION_MAX + 1),
    localparam int AW = (VERSION_MAX > 1) ? $clog2(VERSION_MAX) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmvs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fmvs_pkg::t_in_req               i_in_req,
    input  logic                            i_back_busy,
    input  logic                            i_q_full,
    output logic                            o_job_push,
    output logic [CW-1:0]                   o_job_count,
    output logic                            o_ram_we,
    output logic [AW-1:0]                   o_ram_waddr,
    output logic [7:0]                      o_ram_wdata
);
    logic [63:0]   r_pfx_low;
    logic [63:0]   r_pfx_high;
    logic [4:0]    r_pfx_len;
    logic [4:0]    r_match_cnt;
    logic          r_collecting;
    logic [CW-1:0] r_cap_cnt;
    logic          r_found;

    logic [127:0]  pfx;
    logic [4:0]    eff_len;
    logic [7:0]    c;
    logic [4:0]    mc_base;
    logic          hit;
    logic [4:0]    adv_mc;
    logic          adv_start;
    logic          in_acc;
    logic          is_restart;
    logic          semi_end;
    logic          cap_ok;

    assign pfx = {r_pfx_high, r_pfx_low};
    assign c   = i_in_req.data_byte;

    always_comb begin
        priority if (r_pfx_len == 5'd0) begin
            eff_len = 5'd1;
        end else if (r_pfx_len > 5'(PREFIX_MAX)) begin
            eff_len = 5'(PREFIX_MAX);
        end else begin
            eff_len = r_pfx_len;
        end
    end

    // naive restart matcher; a dropped capture rechecks from zero
    assign mc_base   = r_collecting ? 5'd0 : r_match_cnt;
    assign hit       = (mc_base < eff_len) && (c == pfx[{mc_base[3:0], 3'b000} +: 8]);
    assign adv_mc    = hit ? (mc_base + 5'd1) : ((c == pfx[7:0]) ? 5'd1 : 5'd0);
    assign adv_start = (adv_mc != 5'd0) && (adv_mc == eff_len);

    assign is_restart = (i_in_req.operation == fmvs_pkg::OP_RESTART);
    assign semi_end   = (c == fmvs_pkg::CH_SEMI) && (r_cap_cnt != '0);
    assign cap_ok     = fmvs_pkg::allowed_char(c) && (r_cap_cnt < CW'(VERSION_MAX));

    // a restart waits until the stored version has been read out
    assign o_in_stall = (is_restart && i_back_busy) || i_q_full;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_job_push  = in_acc && !is_restart && !r_found && r_collecting && semi_end;
    assign o_job_count = r_cap_cnt;

    assign o_ram_we    = in_acc && !is_restart && !r_found && r_collecting && !semi_end && cap_ok;
    assign o_ram_waddr = r_cap_cnt[AW-1:0];
    assign o_ram_wdata = c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx_low  <= '0;
            r_pfx_high <= '0;
            r_pfx_len  <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fmvs_pkg::CFG_PREFIX_LOW:  r_pfx_low  <= i_cfg_data;
                fmvs_pkg::CFG_PREFIX_HIGH: r_pfx_high <= i_cfg_data;
                fmvs_pkg::CFG_PREFIX_LEN:  r_pfx_len  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_cnt  <= 5'd0;
            r_collecting <= 1'b0;
            r_cap_cnt    <= '0;
            r_found      <= 1'b0;
        end else if (in_acc) begin
            priority if (is_restart) begin
                r_match_cnt  <= 5'd0;
                r_collecting <= 1'b0;
                r_cap_cnt    <= '0;
                r_found      <= 1'b0;
            end else if (r_found) begin
                // everything ignored until restart
            end else if (!r_collecting) begin
                r_match_cnt <= adv_mc;
                if (adv_start) begin
                    r_collecting <= 1'b1;
                    r_cap_cnt    <= '0;
                end
            end else if (semi_end) begin
                r_found <= 1'b1;
            end else if (cap_ok) begin
                r_cap_cnt <= r_cap_cnt + CW'(1);
            end else begin
                // drop the capture and recheck as first marker byte
                r_match_cnt  <= adv_mc;
                r_collecting <= adv_start;
                r_cap_cnt    <= '0;
            end
        end
    end
endmodule

FILE: rtl/fmvs_back.sv
// readout back: walks the captured version in ram and presents one char per request
module fmvs_back #(
    parameter int VERSION_MAX = fmvs_pkg::VERSION_MAX_DEF,
    localparam int CW = $clog2(VERSION_MAX + 1),
    localparam int AW = (VERSION_MAX > 1) ? $clog2(VERSION_MAX) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [CW-1:0]      i_q_data,
    output logic               o_q_pop,
    output logic               o_ram_re,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [7:0]         i_ram_rdata,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fmvs_pkg::t_out_req o_out_req,
    output logic               o_busy
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;
    localparam logic [1:0] S_SEND  = 2'd3;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_idx;
    logic               r_out_valid;
    fmvs_pkg::t_out_req r_out;

    logic               is_last;
    logic [6:0]         len7;

    assign is_last = ((CW'(r_idx) + CW'(1)) == r_cnt);
    assign len7    = 7'(r_cnt);

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_ram_re    = (r_state == S_FETCH);
    assign o_ram_raddr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_SEND;
                end
                S_SEND: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_out.version_last ? S_IDLE : S_FETCH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cnt <= i_q_data;
            r_idx <= '0;
        end else if ((r_state == S_SEND) && !i_out_stall && !r_out.version_last) begin
            r_idx <= r_idx + AW'(1);
        end
        if (r_state == S_LOAD) begin
            r_out.version_char   <= i_ram_rdata;
            r_out.version_last   <= is_last;
            r_out.version_length <= len7[5:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_busy      = (r_state != S_IDLE);
endmodule

FILE: rtl/firmware_marker_version_scanner_unit.sv
// top level of the firmware marker version scanner
// Scans an image byte stream for a marker of 1 to 16 bytes (set by the prefix
// byte and prefix length registers), then captures the version string that
// follows (alphanumerics and . - _ +) up to VERSION_MAX characters; a ';' after
// at least one character marks the version found and queues a readout of the
// whole string as a run of output requests, the last one flagged. A bad
// character or an overflow drops the capture and the byte is rechecked as the
// first marker byte. Once found, data bytes are taken and ignored until a
// restart request. Rate: the scan front takes one input request every cycle;
// only a restart stalls, and it waits until the readout of the stored version
// has finished. The readout back takes the job from the queue, then for each
// character fetches it from ram, loads it into the output register and
// presents it, holding while the output side stalls. The capture ram
// needs no clearing pass after reset: only written entries are ever read.
module firmware_marker_version_scanner_unit #(
    parameter int VERSION_MAX = fmvs_pkg::VERSION_MAX_DEF,
    parameter int PREFIX_MAX  = fmvs_pkg::PREFIX_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fmvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmvs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fmvs_pkg::t_in_req               i_in_req,
    // output request channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fmvs_pkg::t_out_req              o_out_req
);
    localparam int CW = $clog2(VERSION_MAX + 1);
    localparam int AW = (VERSION_MAX > 1) ? $clog2(VERSION_MAX) : 1;

    // front to queue
    logic          job_push;
    logic [CW-1:0] job_count;
    // queue to back
    logic          q_pop;
    logic [CW-1:0] q_data;
    logic          q_empty;
    logic          q_full;
    // capture ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    // readout still pending anywhere in the back half
    logic          back_active;
    logic          back_busy;

    assign back_busy = back_active || !q_empty;

    fmvs_front #(
        .VERSION_MAX (VERSION_MAX),
        .PREFIX_MAX  (PREFIX_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_back_busy (back_busy),
        .i_q_full    (q_full),
        .o_job_push  (job_push),
        .o_job_count (job_count),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    // captured version characters
    fmvs_ram #(
        .WIDTH (8),
        .DEPTH (VERSION_MAX)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // readout jobs: the version length to stream out
    fmvs_job_q #(
        .W (CW)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_count),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fmvs_back #(
        .VERSION_MAX (VERSION_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .o_busy      (back_active)
    );
endmodule

FILE: rtl/fmvs_checker.sv
// port-level checker of the scanner, bound to the top level
`include "assert_macros.svh"

module fmvs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fmvs_pkg::t_in_req  i_in_req,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fmvs_pkg::t_out_req o_out_req
);
    logic restart_acc;
    logic out_acc;

    assign restart_acc = i_in_valid && !o_in_stall &&
                         (i_in_req.operation == fmvs_pkg::OP_RESTART);
    assign out_acc     = o_out_valid && !i_out_stall;

    // stalled output request holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
                 o_out_valid && $stable(o_out_req))

    // a restart never overtakes a version readout
    `ASSERT_IMPL(a_no_restart_in_readout, i_clk, i_rst_n, o_out_valid, !restart_acc)

    // each character is fetched from the ram anew after the previous is taken
    `ASSERT_NEXT(a_gap_after_char, i_clk, i_rst_n, out_acc, !o_out_valid)
endmodule

bind firmware_marker_version_scanner_unit fmvs_checker u_fmvs_checker (.*);
